// ----- hdl/baro_pkg.sv -----
// Shared types, constants and helpers for the barometer compensation block.
// No dependencies; used by baro_div and barometer_raw_compensation_top.

package baro_pkg;

    localparam int C_WORD_W = 32;
    localparam int C_RAW_W  = 19;
    localparam int C_OSS    = 0;    // oversampling setting, 0..3

    // APB register map, index = paddr[4:2]
    localparam int C_ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_CAL_A1   = 3'd0,
        REG_CAL_A2   = 3'd1,
        REG_CAL_A3   = 3'd2,
        REG_CAL_A4   = 3'd3,
        REG_BIAS_ONE = 3'd4,
        REG_BIAS_TWO = 3'd5,
        REG_TEMP_OG  = 3'd6,
        REG_TEMP_CRV = 3'd7
    } t_reg_idx;

    typedef enum logic {
        OP_TEMP  = 1'b0,
        OP_PRESS = 1'b1
    } t_opcode;

    localparam logic [C_WORD_W-1:0] C_B6_OFFSET = 32'd4000;
    localparam logic [C_WORD_W-1:0] C_B4_BIAS   = 32'd32768;
    localparam logic [C_WORD_W-1:0] C_B7_SCALE  = 32'(50000 >> C_OSS);
    localparam logic [C_WORD_W-1:0] C_K1        = 32'd3038;
    localparam logic [C_WORD_W-1:0] C_K2        = 32'hFFFF_E343;  // -7357
    localparam logic [C_WORD_W-1:0] C_K3        = 32'd3791;
    localparam logic [C_WORD_W-1:0] C_ROUND_T   = 32'd8;
    localparam logic [C_WORD_W-1:0] C_ROUND_P   = 32'd2;

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_T_MUL = 17'b00000000000000010,
        S_T_DEN = 17'b00000000000000100,
        S_T_DIV = 17'b00000000000001000,
        S_P_SQ  = 17'b00000000000010000,
        S_P_X1  = 17'b00000000000100000,
        S_P_X2  = 17'b00000000001000000,
        S_P_B3  = 17'b00000000010000000,
        S_P_B1  = 17'b00000000100000000,
        S_P_X3  = 17'b00000001000000000,
        S_P_B4  = 17'b00000010000000000,
        S_P_CHK = 17'b00000100000000000,
        S_P_DIV = 17'b00001000000000000,
        S_P_C1  = 17'b00010000000000000,
        S_P_C2  = 17'b00100000000000000,
        S_P_FIN = 17'b01000000000000000,
        S_OUT   = 17'b10000000000000000
    } t_state;

    function automatic logic [C_WORD_W-1:0] f_asr(input logic [C_WORD_W-1:0] v,
                                                  input int unsigned n);
        f_asr = C_WORD_W'($signed(v) >>> n);
    endfunction

    function automatic logic [C_WORD_W-1:0] f_sx16(input logic [15:0] v);
        f_sx16 = {{(C_WORD_W-16){v[15]}}, v};
    endfunction

endpackage

// ----- hdl/baro_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Uses baro_pkg for the default word width.

module baro_div #(
    parameter int W = baro_pkg::C_WORD_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    import baro_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0] w_shift;
    logic [W:0] w_diff;
    logic       w_ge;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- hdl/barometer_raw_compensation_top.sv -----
// Barometer raw-reading compensation: sequencer, shared multiplier, APB registers.
// Depends on baro_pkg and baro_div.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+----------------------------------
//  s_*       | in  | s_tvalid / s_tready       | tdata: raw_reading; tuser: opcode
//  m_*       | out | m_tvalid / m_tready       | tdata: compensated;
//            |     |                           | tuser: is_pressure, divide_fault
//  APB       | in  | psel & penable & pwrite   | paddr[4:2] selects register
//
//  A temperature item runs through the S_T_* states and a pressure item through the
//  S_P_* states, both ending in S_OUT; the divider, skipped on a zero divisor, takes
//  32 steps, and the other states share the single 32x32 multiplier. One item is
//  worked on at a time; s_tready is high only while the sequencer is idle. A finished
//  result sits in the output register while the next item is accepted; if it has not
//  been taken when the next result is ready, the sequencer holds. Reset clears the APB
//  registers, the output valid and the stored B5 to zero.

module barometer_raw_compensation_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // [18:0] raw_reading
    input  logic [0:0]                        s_tuser,   // [0] opcode
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [baro_pkg::C_WORD_W-1:0]     m_tdata,   // [31:0] compensated
    output logic [1:0]                        m_tuser,   // [0] is_pressure, [1] divide_fault
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [baro_pkg::C_ADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import baro_pkg::*;

    // configuration registers
    logic [15:0] r_cal_a1, r_cal_a2, r_cal_a3, r_cal_a4, r_bias_one, r_bias_two;
    logic [31:0] r_temp_og, r_temp_crv;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a1   <= '0;
            r_cal_a2   <= '0;
            r_cal_a3   <= '0;
            r_cal_a4   <= '0;
            r_bias_one <= '0;
            r_bias_two <= '0;
            r_temp_og  <= '0;
            r_temp_crv <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_CAL_A1:   r_cal_a1   <= pwdata[15:0];
                REG_CAL_A2:   r_cal_a2   <= pwdata[15:0];
                REG_CAL_A3:   r_cal_a3   <= pwdata[15:0];
                REG_CAL_A4:   r_cal_a4   <= pwdata[15:0];
                REG_BIAS_ONE: r_bias_one <= pwdata[15:0];
                REG_BIAS_TWO: r_bias_two <= pwdata[15:0];
                REG_TEMP_OG:  r_temp_og  <= pwdata;
                REG_TEMP_CRV: r_temp_crv <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CAL_A1:   prdata = {16'b0, r_cal_a1};
            REG_CAL_A2:   prdata = {16'b0, r_cal_a2};
            REG_CAL_A3:   prdata = {16'b0, r_cal_a3};
            REG_CAL_A4:   prdata = {16'b0, r_cal_a4};
            REG_BIAS_ONE: prdata = {16'b0, r_bias_one};
            REG_BIAS_TWO: prdata = {16'b0, r_bias_two};
            REG_TEMP_OG:  prdata = r_temp_og;
            REG_TEMP_CRV: prdata = r_temp_crv;
            default:      prdata = '0;
        endcase
    end

    // sequencer and datapath registers
    t_state               r_state;
    logic                 r_op;
    logic [C_RAW_W-1:0]   r_raw;
    logic [C_WORD_W-1:0]  r_ti;      // stored B5
    logic [C_WORD_W-1:0]  r_prod;
    logic [C_WORD_W-1:0]  r_x1, r_b6, r_sq, r_b3, r_x3, r_b7, r_p;
    logic                 r_neg;
    logic                 r_dbl;
    logic [C_WORD_W-1:0]  r_res;
    logic                 r_fault;
    logic                 r_m_valid;
    logic [C_WORD_W-1:0]  r_m_data;
    logic [1:0]           r_m_user;

    // shared multiplier
    logic [C_WORD_W-1:0] w_ma, w_mb, w_prod;

    // divider hookup
    logic                w_div_start;
    logic [C_WORD_W-1:0] w_div_num, w_div_den, w_quo;
    logic                w_div_done;

    // derived values
    logic [C_WORD_W-1:0] w_ac5, w_ac6, w_mc, w_md;
    logic [C_WORD_W-1:0] w_t_x1, w_den, w_num_t, w_q_t, w_b5;
    logic [C_WORD_W-1:0] w_b6, w_sq, w_x3a, w_b3, w_b4, w_p, w_p8;

    assign w_ac5 = {16'b0, r_temp_og[15:0]};
    assign w_ac6 = {16'b0, r_temp_og[31:16]};
    assign w_mc  = f_sx16(r_temp_crv[31:16]);
    assign w_md  = f_sx16(r_temp_crv[15:0]);

    assign w_t_x1  = f_asr(r_prod, 15);
    assign w_den   = w_t_x1 + w_md;
    assign w_num_t = w_mc << 11;
    assign w_q_t   = r_neg ? (C_WORD_W'(0) - w_quo) : w_quo;
    assign w_b5    = r_x1 + w_q_t;

    assign w_b6  = r_ti - C_B6_OFFSET;
    assign w_sq  = f_asr(r_prod, 12);
    assign w_x3a = r_x1 + f_asr(r_prod, 11);
    assign w_b3  = f_asr((((f_sx16(r_cal_a1) << 2) + w_x3a) << C_OSS) + C_ROUND_P, 2);
    assign w_b4  = r_prod >> 15;
    assign w_p   = r_dbl ? (w_quo << 1) : w_quo;
    assign w_p8  = f_asr(w_p, 8);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_T_MUL: begin
                w_ma = {16'b0, r_raw[15:0]} - w_ac6;
                w_mb = w_ac5;
            end
            S_P_SQ: begin
                w_ma = w_b6;
                w_mb = w_b6;
            end
            S_P_X1: begin
                w_ma = f_sx16(r_bias_two);
                w_mb = w_sq;
            end
            S_P_X2: begin
                w_ma = f_sx16(r_cal_a2);
                w_mb = r_b6;
            end
            S_P_B3: begin
                w_ma = f_sx16(r_cal_a3);
                w_mb = r_b6;
            end
            S_P_B1: begin
                w_ma = f_sx16(r_bias_one);
                w_mb = r_sq;
            end
            S_P_X3: begin
                w_ma = C_WORD_W'(r_raw) - r_b3;
                w_mb = C_B7_SCALE;
            end
            S_P_B4: begin
                w_ma = {16'b0, r_cal_a4};
                w_mb = r_x3 + C_B4_BIAS;
            end
            S_P_DIV: begin
                w_ma = w_p8;
                w_mb = w_p8;
            end
            S_P_C1: begin
                w_ma = r_prod;
                w_mb = C_K1;
            end
            S_P_C2: begin
                w_ma = C_K2;
                w_mb = r_p;
            end
            default: ;
        endcase
    end

    assign w_prod = C_WORD_W'(w_ma * w_mb);

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            S_T_DEN: begin
                w_div_start = (w_den != '0);
                w_div_num   = w_num_t[C_WORD_W-1] ? (C_WORD_W'(0) - w_num_t) : w_num_t;
                w_div_den   = w_den[C_WORD_W-1] ? (C_WORD_W'(0) - w_den) : w_den;
            end
            S_P_CHK: begin
                w_div_start = (w_b4 != '0);
                w_div_num   = r_b7[C_WORD_W-1] ? r_b7 : (r_b7 << 1);
                w_div_den   = w_b4;
            end
            default: ;
        endcase
    end

    baro_div #(
        .W (C_WORD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ti      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // load a new result when the output register is free, else drop a taken one
            if (r_state == S_OUT && (!r_m_valid || m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_state <= (t_opcode'(s_tuser[0]) == OP_PRESS) ? S_P_SQ : S_T_MUL;
                    end
                end
                S_T_MUL: r_state <= S_T_DEN;
                S_T_DEN: r_state <= (w_den == '0) ? S_OUT : S_T_DIV;
                S_T_DIV: begin
                    if (w_div_done) begin
                        r_ti    <= w_b5;
                        r_state <= S_OUT;
                    end
                end
                S_P_SQ:  r_state <= S_P_X1;
                S_P_X1:  r_state <= S_P_X2;
                S_P_X2:  r_state <= S_P_B3;
                S_P_B3:  r_state <= S_P_B1;
                S_P_B1:  r_state <= S_P_X3;
                S_P_X3:  r_state <= S_P_B4;
                S_P_B4:  r_state <= S_P_CHK;
                S_P_CHK: r_state <= (w_b4 == '0) ? S_OUT : S_P_DIV;
                S_P_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_P_C1;
                    end
                end
                S_P_C1:  r_state <= S_P_C2;
                S_P_C2:  r_state <= S_P_FIN;
                S_P_FIN: r_state <= S_OUT;
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_m_valid || m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            S_IDLE: begin
                r_op    <= s_tuser[0];
                r_raw   <= s_tdata[C_RAW_W-1:0];
                r_res   <= '0;
                r_fault <= 1'b0;
            end
            S_T_DEN: begin
                r_x1  <= w_t_x1;
                r_neg <= w_num_t[C_WORD_W-1] ^ w_den[C_WORD_W-1];
                if (w_den == '0) begin
                    r_res   <= '0;
                    r_fault <= 1'b1;
                end
            end
            S_T_DIV: r_res <= f_asr(w_b5 + C_ROUND_T, 4);
            S_P_SQ:  r_b6  <= w_b6;
            S_P_X1:  r_sq  <= w_sq;
            S_P_X2:  r_x1  <= f_asr(r_prod, 11);
            S_P_B3:  r_b3  <= w_b3;
            S_P_B1:  r_x1  <= f_asr(r_prod, 13);
            S_P_X3:  r_x3  <= f_asr(r_x1 + f_asr(r_prod, 16) + C_ROUND_P, 2);
            S_P_B4:  r_b7  <= r_prod;
            S_P_CHK: begin
                r_dbl <= r_b7[C_WORD_W-1];
                if (w_b4 == '0) begin
                    r_res   <= '0;
                    r_fault <= 1'b1;
                end
            end
            S_P_DIV: r_p  <= w_p;
            S_P_C2:  r_x1 <= f_asr(r_prod, 16);
            S_P_FIN: r_res <= r_p + f_asr(r_x1 + f_asr(r_prod, 16) + C_K3, 4);
            S_OUT: begin
                if (!r_m_valid || m_tready) begin
                    r_m_data <= r_res;
                    r_m_user <= {r_fault, r_op};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for barometer_raw_compensation_top: stream items in, results out.
// Depends on baro_pkg and the RTL; predicts results in a local scoreboard class.

module testbench;
    import baro_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 110;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_BIAS     = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] SQ_GAIN     = 32'd3038;
    localparam logic [31:0] LIN_GAIN    = -32'sd7357;
    localparam logic [31:0] FINAL_BIAS  = 32'd3791;

    typedef struct packed {
        logic        is_pressure;
        logic [31:0] value;
        logic        divide_fault;
    } reading_t;

    class reading_scoreboard;
        logic [31:0] cal [8];
        logic [31:0] b5_held;
        reading_t    pending_readings [$];
        int unsigned mismatches;

        function new();
            foreach (cal[k]) cal[k] = '0;
            b5_held    = '0;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            cal[idx] = value;
        endfunction

        function logic [31:0] sra(logic [31:0] v, int unsigned n);
            return $signed(v) >>> n;
        endfunction

        function logic [31:0] widen(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        // signed quotient, truncated toward zero, built on magnitudes
        function logic [31:0] quot_trunc(logic [31:0] num, logic [31:0] den);
            logic [31:0] num_mag;
            logic [31:0] den_mag;
            logic [31:0] q;
            num_mag = num[31] ? -num : num;
            den_mag = den[31] ? -den : den;
            q = num_mag / den_mag;
            return (num[31] != den[31]) ? -q : q;
        endfunction

        function reading_t compensate(t_opcode op, logic [18:0] raw);
            reading_t    r;
            logic [31:0] ut, ac5, ac6, mc, md, x1, x2, x3, den;
            logic [31:0] ac1, ac2, ac3, ac4, b1, b2, b3, b4, b6, b7, sq, p;
            r.is_pressure  = op;
            r.value        = '0;
            r.divide_fault = 1'b0;
            if (op == OP_TEMP) begin
                ut  = {16'd0, raw[15:0]};
                ac5 = {16'd0, cal[REG_TEMP_OG][15:0]};
                ac6 = {16'd0, cal[REG_TEMP_OG][31:16]};
                mc  = widen(cal[REG_TEMP_CRV][31:16]);
                md  = widen(cal[REG_TEMP_CRV][15:0]);
                x1  = sra((ut - ac6) * ac5, 15);
                den = x1 + md;
                // zero divisor: flag it and keep the stored B5
                if (den == 0) begin
                    r.divide_fault = 1'b1;
                end else begin
                    b5_held = x1 + quot_trunc(mc << 11, den);
                    r.value = sra(b5_held + 32'd8, 4);
                end
            end else begin
                ac1 = widen(cal[REG_CAL_A1][15:0]);
                ac2 = widen(cal[REG_CAL_A2][15:0]);
                ac3 = widen(cal[REG_CAL_A3][15:0]);
                ac4 = {16'd0, cal[REG_CAL_A4][15:0]};
                b1  = widen(cal[REG_BIAS_ONE][15:0]);
                b2  = widen(cal[REG_BIAS_TWO][15:0]);
                b6  = b5_held - B6_OFFSET;
                sq  = sra(b6 * b6, 12);
                x3  = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
                b3  = sra(((ac1 * 32'd4 + x3) << C_OSS) + 32'd2, 2);
                x3  = sra(sra(ac3 * b6, 13) + sra(b1 * sq, 16) + 32'd2, 2);
                b4  = (ac4 * (x3 + B4_BIAS)) >> 15;
                b7  = ({13'd0, raw} - b3) * (B7_SCALE >> C_OSS);
                if (b4 == 0) begin
                    r.divide_fault = 1'b1;
                end else begin
                    // keep the doubling inside 32 bits
                    if (b7[31] == 1'b0) p = (b7 << 1) / b4;
                    else p = (b7 / b4) << 1;
                    x1 = sra(p, 8) * sra(p, 8);
                    x1 = sra(x1 * SQ_GAIN, 16);
                    x2 = sra(LIN_GAIN * p, 16);
                    r.value = p + sra(x1 + x2 + FINAL_BIAS, 4);
                end
            end
            return r;
        endfunction

        function void note_reading(t_opcode op, logic [18:0] raw);
            pending_readings.push_back(compensate(op, raw));
        endfunction

        function void check_reading(logic is_pressure, logic [31:0] value, logic fault);
            reading_t want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: p=%0b val=%0d fault=%0b",
                             is_pressure, $signed(value), fault);
                return;
            end
            want = pending_readings.pop_front();
            if (is_pressure !== want.is_pressure || value !== want.value ||
                fault !== want.divide_fault) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected p=%0b val=%0d fault=%0b, got p=%0b val=%0d fault=%0b",
                             want.is_pressure, $signed(want.value), want.divide_fault,
                             is_pressure, $signed(value), fault);
            end
        endfunction

        function int outstanding();
            return pending_readings.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;      // [18:0] raw_reading
    logic [0:0]  s_tuser;      // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // [31:0] compensated
    logic [1:0]  m_tuser;      // [0] is_pressure, [1] divide_fault
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [C_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reading_scoreboard sb;
    bit idle_on     = 1'b1;
    int holds_asked = 0;

    barometer_raw_compensation_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // write all eight registers; 16-bit words carry random upper bits
    task automatic program_cal(input int a1, a2, a3, a4, b1, b2, ac5, ac6, mc, md);
        logic [31:0] word [8];
        t_reg_idx    idx;
        word[REG_CAL_A1]   = {16'($urandom), a1[15:0]};
        word[REG_CAL_A2]   = {16'($urandom), a2[15:0]};
        word[REG_CAL_A3]   = {16'($urandom), a3[15:0]};
        word[REG_CAL_A4]   = {16'($urandom), a4[15:0]};
        word[REG_BIAS_ONE] = {16'($urandom), b1[15:0]};
        word[REG_BIAS_TWO] = {16'($urandom), b2[15:0]};
        word[REG_TEMP_OG]  = {ac6[15:0], ac5[15:0]};
        word[REG_TEMP_CRV] = {mc[15:0], md[15:0]};
        for (int k = 0; k < 8; k++) begin
            idx = t_reg_idx'(k);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= word[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            sb.write_reg(idx, word[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_typical_cal();
        program_cal(408 + jitter(2000), -72 + jitter(500), -14383 + jitter(1000),
                    32741 + jitter(2000), 6190 + jitter(1000), 4 + jitter(40),
                    32757 + jitter(2000), 23153 + jitter(2000),
                    -8711 + jitter(1000), 2868 + jitter(300));
    endtask

    task automatic send_item(input t_opcode op, input logic [18:0] raw);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, raw};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        sb.note_reading(op, raw);
    endtask

    task automatic send_random(input bit typical);
        t_opcode     op;
        logic [18:0] raw;
        op  = t_opcode'($urandom_range(0, 1));
        raw = 19'($urandom);
        // mostly plausible counts for a plausible sensor, the rest noise
        if (typical && $urandom_range(0, 4) != 0) begin
            if (op == OP_TEMP) raw[15:0] = 16'($urandom_range(20000, 36000));
            else raw = 19'($urandom_range(14000, 42000));
        end
        send_item(op, raw);
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // result side: check, then decide tready for the next edge
    initial begin : result_sink
        int rx_wait;
        int holds_taken;
        m_tready    = 1'b0;
        rx_wait     = 0;
        holds_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid === 1'b1 && m_tready)
                sb.check_reading(m_tuser[0], m_tdata, m_tuser[1]);
            if (holds_taken != holds_asked) begin
                holds_taken = holds_asked;
                rx_wait     = LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                rx_wait   = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        sb       = new();
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: both divisors are zero, pressure sees B5 of zero
        send_item(OP_PRESS, 19'd0);
        send_item(OP_TEMP, 19'd0);
        send_item(OP_TEMP, 19'h0FFFF);
        send_item(OP_PRESS, 19'h7FFFF);
        s_tvalid <= 1'b0;
        drain_results();

        // datasheet calibration and its worked example
        program_cal(408, -72, -14383, 32741, 6190, 4, 32757, 23153, -8711, 2868);
        send_item(OP_TEMP, 19'd27898);
        send_item(OP_PRESS, 19'd23843);
        send_item(OP_TEMP, 19'd0);
        send_item(OP_PRESS, 19'd0);
        send_item(OP_TEMP, 19'h7FFFF);
        send_item(OP_PRESS, 19'h7FFFF);
        s_tvalid <= 1'b0;
        drain_results();

        // unit gain, no offset: low counts divide by zero and must keep B5
        program_cal(408, -72, -14383, 32741, 6190, 4, 1, 0, -8711, 0);
        send_item(OP_TEMP, 19'h08000);
        send_item(OP_TEMP, 19'h01234);
        send_item(OP_PRESS, 19'h3FFFF);
        s_tvalid <= 1'b0;
        drain_results();

        program_cal(32767, 32767, 32767, 65535, 32767, 32767, 65535, 65535, 32767, 32767);
        send_item(OP_TEMP, 19'd0);
        send_item(OP_PRESS, 19'd0);
        send_item(OP_TEMP, 19'h7FFFF);
        send_item(OP_PRESS, 19'h7FFFF);
        s_tvalid <= 1'b0;
        drain_results();

        program_cal(-32768, -32768, -32768, 0, -32768, -32768, 0, 0, -32768, -32768);
        send_item(OP_TEMP, 19'h7FFFF);
        send_item(OP_PRESS, 19'h55555);
        send_item(OP_PRESS, 19'h2AAAA);
        s_tvalid <= 1'b0;
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph % 3 == 2)
                program_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                program_typical_cal();
            idle_on <= (ph != PHASES - 1) && (ph % 4 != 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stall the result side long enough to back up the input
                if (ph == 1 && i == 20) holds_asked <= holds_asked + 1;
                if (ph == 2 && i == 55) begin
                    s_tvalid <= 1'b0;
                    drain_results();
                end
                send_random(ph % 3 != 2);
            end
            s_tvalid <= 1'b0;
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- barometer_raw_compensation_top.f -----
hdl/baro_pkg.sv
hdl/baro_div.sv
hdl/barometer_raw_compensation_top.sv
bench/testbench.sv
